// File: src/weighted_adjacency_matrix_store_defines.svh
// Assertion macros shared by the RTL files.
`ifndef WEIGHTED_ADJACENCY_MATRIX_STORE_DEFINES_SVH
`define WEIGHTED_ADJACENCY_MATRIX_STORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/wams_pkg.sv
package wams_pkg;

   // Fixed field widths of the ports and of the vertex-count compare
   localparam int VERTEX_BITS  = 6;
   localparam int WEIGHT_FIELD = 16;
   localparam int COUNT_BITS   = 7;
   localparam int TOTAL_BITS   = 16;
   localparam int VC_BITS      = 7;
   localparam int CMP_BITS     = 9;

   typedef logic [2:0] cmd_type;
   localparam cmd_type CMD_ADD      = 3'd0;
   localparam cmd_type CMD_REMOVE   = 3'd1;
   localparam cmd_type CMD_TEST     = 3'd2;
   localparam cmd_type CMD_DEGREE   = 3'd3;
   localparam cmd_type CMD_LIST     = 3'd4;
   localparam cmd_type CMD_LIGHTEST = 3'd5;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_RANGE = 2'd1;
   localparam status_type STATUS_NONE  = 2'd2;

   localparam logic [VC_BITS-1:0]    VERTEX_COUNT_RESET = 7'd64;
   localparam logic [COUNT_BITS-1:0] LIST_LIMIT         = 7'd64;

   localparam logic signed [TOTAL_BITS-1:0] COUNTER_MAX = 16'sh7FFF;
   localparam logic signed [TOTAL_BITS-1:0] COUNTER_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      OUT_RANGE,
      OUT_NONE,
      OUT_OK,
      OUT_TEST,
      OUT_DEGREE,
      OUT_LIST_END,
      OUT_LIGHTEST
   } out_kind_type;

   typedef struct packed {
      logic         clear_step;
      logic         latch_in;
      logic         write_fwd;
      logic         write_rev;
      logic         use_best;
      logic         write_zero;
      logic         read_pair;
      logic         scan_start;
      logic         scan_step;
      logic         bump_up;
      logic         bump_down;
      logic         out_load;
      out_kind_type out_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic    clear_done;
      logic    pair_ok;
      logic    row_ok;
      logic    scan_done;
      logic    best_found;
      logic    out_free;
      cmd_type cmd;
   } dp_status_type;

endpackage

// File: src/weighted_adjacency_matrix_store.sv
// channel   | direction | handshake            | beat
// req_*     | in        | req_valid/req_stall  | cmd, row/col vertex, edge weight
// rsp_*     | out       | rsp_valid/rsp_stall  | status, edge/neighbour data, last
// csr_*     | in        | csr_write_enable     | vertex_count
//
// After reset a clearing pass zeroes all MAX_VERTICES*MAX_VERTICES words
// (4096 by default), one word a cycle; req_stall stays high.
// Add/remove run decode, forward write and reverse write, test decode and
// a pair read, unknown or out-of-range commands decode alone, before the
// result beat goes to the output register. Degree and list walk one row
// through the single RAM read port; lightest-edge walks (n-1)^2 words.
// A list beat waiting on rsp_stall holds the row walk; one item at a time.
module weighted_adjacency_matrix_store #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic [5:0]         req_row_vertex,
   input  logic [5:0]         req_col_vertex,
   input  logic [15:0]        req_edge_weight,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_edge_present,
   output logic [5:0]         rsp_vertex_a,
   output logic [5:0]         rsp_vertex_b,
   output logic [15:0]        rsp_found_weight,
   output logic [6:0]         rsp_neighbour_count,
   output logic signed [15:0] rsp_edges_total,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [6:0]         csr_write_data
);

   wams_pkg::ctrl_cmd_type  cmd;
   wams_pkg::dp_status_type sts;

   wams_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wams_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_cmd             (req_cmd),
      .req_row_vertex      (req_row_vertex),
      .req_col_vertex      (req_col_vertex),
      .req_edge_weight     (req_edge_weight),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_edge_present    (rsp_edge_present),
      .rsp_vertex_a        (rsp_vertex_a),
      .rsp_vertex_b        (rsp_vertex_b),
      .rsp_found_weight    (rsp_found_weight),
      .rsp_neighbour_count (rsp_neighbour_count),
      .rsp_edges_total     (rsp_edges_total),
      .rsp_last            (rsp_last)
   );

endmodule

// File: src/wams_ram.sv
module wams_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/wams_ctrl.sv
`include "weighted_adjacency_matrix_store_defines.svh"

module wams_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  wams_pkg::dp_status_type sts,
   output wams_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [9:0] {
      ST_CLEAR     = 10'b00_0000_0001,
      ST_IDLE      = 10'b00_0000_0010,
      ST_DECODE    = 10'b00_0000_0100,
      ST_WRITE_FWD = 10'b00_0000_1000,
      ST_WRITE_REV = 10'b00_0001_0000,
      ST_TEST_READ = 10'b00_0010_0000,
      ST_SCAN      = 10'b00_0100_0000,
      ST_DEL_FWD   = 10'b00_1000_0000,
      ST_DEL_REV   = 10'b01_0000_0000,
      ST_EMIT      = 10'b10_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   wams_pkg::out_kind_type kind_ff, kind_in;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.out_kind = kind_ff;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch_in = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.cmd) inside
               wams_pkg::CMD_ADD, wams_pkg::CMD_REMOVE: begin
                  if (sts.pair_ok) begin
                     state_in = ST_WRITE_FWD;
                  end else begin
                     kind_in  = wams_pkg::OUT_RANGE;
                     state_in = ST_EMIT;
                  end
               end
               wams_pkg::CMD_TEST: begin
                  if (sts.pair_ok) begin
                     state_in = ST_TEST_READ;
                  end else begin
                     kind_in  = wams_pkg::OUT_RANGE;
                     state_in = ST_EMIT;
                  end
               end
               wams_pkg::CMD_DEGREE, wams_pkg::CMD_LIST: begin
                  if (sts.row_ok) begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end else begin
                     kind_in  = wams_pkg::OUT_RANGE;
                     state_in = ST_EMIT;
                  end
               end
               wams_pkg::CMD_LIGHTEST: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
               default: begin
                  kind_in  = wams_pkg::OUT_NONE;
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_WRITE_FWD: begin
            cmd.write_fwd  = 1'b1;
            cmd.write_zero = (sts.cmd == wams_pkg::CMD_REMOVE);
            state_in       = ST_WRITE_REV;
         end
         ST_WRITE_REV: begin
            cmd.write_rev  = 1'b1;
            cmd.write_zero = (sts.cmd == wams_pkg::CMD_REMOVE);
            cmd.bump_up    = (sts.cmd == wams_pkg::CMD_ADD);
            cmd.bump_down  = (sts.cmd == wams_pkg::CMD_REMOVE);
            kind_in        = wams_pkg::OUT_OK;
            state_in       = ST_EMIT;
         end
         ST_TEST_READ: begin
            cmd.read_pair = 1'b1;
            kind_in       = wams_pkg::OUT_TEST;
            state_in      = ST_EMIT;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               unique case (sts.cmd)
                  wams_pkg::CMD_DEGREE: begin
                     kind_in  = wams_pkg::OUT_DEGREE;
                     state_in = ST_EMIT;
                  end
                  wams_pkg::CMD_LIST: begin
                     kind_in  = wams_pkg::OUT_LIST_END;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     if (sts.best_found) begin
                        state_in = ST_DEL_FWD;
                     end else begin
                        kind_in  = wams_pkg::OUT_NONE;
                        state_in = ST_EMIT;
                     end
                  end
               endcase
            end
         end
         ST_DEL_FWD: begin
            cmd.write_fwd  = 1'b1;
            cmd.use_best   = 1'b1;
            cmd.write_zero = 1'b1;
            state_in       = ST_DEL_REV;
         end
         ST_DEL_REV: begin
            cmd.write_rev  = 1'b1;
            cmd.use_best   = 1'b1;
            cmd.write_zero = 1'b1;
            cmd.bump_down  = 1'b1;
            kind_in        = wams_pkg::OUT_LIGHTEST;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for room in the output register
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff  <= wams_pkg::OUT_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   `ASSERT_NEXT(a_accept_decodes, clock, reset, req_valid && !req_stall, state_ff == ST_DECODE)
   `ASSERT_NEXT(a_emit_returns_idle, clock, reset, state_ff == ST_EMIT && sts.out_free, state_ff == ST_IDLE)

endmodule

// File: src/wams_datapath.sv
`include "weighted_adjacency_matrix_store_defines.svh"

module wams_datapath #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wams_pkg::ctrl_cmd_type         cmd,
   output wams_pkg::dp_status_type        sts,
   input  logic [2:0]                     req_cmd,
   input  logic [5:0]                     req_row_vertex,
   input  logic [5:0]                     req_col_vertex,
   input  logic [15:0]                    req_edge_weight,
   input  logic                           csr_write_enable,
   input  logic [6:0]                     csr_write_data,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_edge_present,
   output logic [5:0]                     rsp_vertex_a,
   output logic [5:0]                     rsp_vertex_b,
   output logic [15:0]                    rsp_found_weight,
   output logic [6:0]                     rsp_neighbour_count,
   output logic signed [15:0]             rsp_edges_total,
   output logic                           rsp_last
);

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int VB    = wams_pkg::VERTEX_BITS;
   localparam int FB    = wams_pkg::WEIGHT_FIELD;
   localparam int NB    = wams_pkg::COUNT_BITS;
   localparam int TB    = wams_pkg::TOTAL_BITS;
   localparam int CB    = wams_pkg::CMP_BITS;

   function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] a, input logic [VW-1:0] b);
      return AW'(a) * AW'(MAX_VERTICES) + AW'(b);
   endfunction

   // configuration
   logic [wams_pkg::VC_BITS-1:0] vc_ff;

   // latched item
   wams_pkg::cmd_type  in_cmd_ff;
   logic [VB-1:0]      in_row_ff, in_col_ff;
   logic [WEIGHT_BITS-1:0] in_weight_ff;

   // clearing sweep
   logic [AW-1:0] clr_addr_ff;

   // scan
   logic [VW-1:0] srow_ff, scol_ff, drow_ff, dcol_ff;
   logic          issue_more_ff, dvalid_ff;
   logic [NB-1:0] cnt_ff, k_ff;
   logic          pend_valid_ff;
   logic [VW-1:0] pend_ff;
   logic          found_ff;
   logic [WEIGHT_BITS-1:0] best_ff;
   logic [VW-1:0] ba_ff, bb_ff;

   logic signed [TB-1:0] counter_ff;

   // output register
   logic                rsp_valid_ff;
   wams_pkg::status_type rsp_status_ff;
   logic                rsp_present_ff;
   logic [VB-1:0]       rsp_va_ff, rsp_vb_ff;
   logic [FB-1:0]       rsp_weight_ff;
   logic [NB-1:0]       rsp_count_ff;
   logic signed [TB-1:0] rsp_total_ff;
   logic                rsp_last_ff;

   // combinational
   logic [CB-1:0] vc_ext, max_ext, n_m1_ext;
   logic [VW-1:0] n_m1, lim_m1, in_row_v, in_col_v, pa, pb;
   logic          row_ok, col_ok, out_free;
   logic          list_mode, matrix_mode;
   logic          hit, hold, advance, consume, list_hit, limit_hit, issue, mid_load;
   logic          better, last_issue;
   logic [NB-1:0] k_next;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [WEIGHT_BITS-1:0] wr_data, rd_data;

   wams_pkg::status_type o_status;
   logic                o_present;
   logic [VB-1:0]       o_va, o_vb;
   logic [FB-1:0]       o_weight;
   logic [NB-1:0]       o_count;
   logic                o_last;

   // effective vertex count minus one: zero acts as one, above the size clamps
   always_comb begin
      vc_ext  = CB'(vc_ff);
      max_ext = CB'(MAX_VERTICES);
      if (vc_ext == '0) begin
         n_m1_ext = '0;
      end else if (vc_ext > max_ext) begin
         n_m1_ext = max_ext - 1'b1;
      end else begin
         n_m1_ext = vc_ext - 1'b1;
      end
   end

   assign n_m1     = VW'(n_m1_ext);
   assign lim_m1   = n_m1 - 1'b1;
   assign in_row_v = VW'(in_row_ff);
   assign in_col_v = VW'(in_col_ff);
   assign row_ok   = CB'(in_row_ff) <= n_m1_ext;
   assign col_ok   = CB'(in_col_ff) <= n_m1_ext;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign list_mode   = (in_cmd_ff == wams_pkg::CMD_LIST);
   assign matrix_mode = (in_cmd_ff == wams_pkg::CMD_LIGHTEST);

   // scan control: hold the read word while a list beat waits for room
   assign hit       = dvalid_ff && (rd_data != '0);
   assign hold      = list_mode && hit && pend_valid_ff && !out_free;
   assign advance   = cmd.scan_step && !hold;
   assign consume   = advance && dvalid_ff;
   assign list_hit  = consume && list_mode && hit;
   assign k_next    = k_ff + NB'(list_hit);
   assign limit_hit = list_hit && (k_next == wams_pkg::LIST_LIMIT);
   assign issue     = advance && issue_more_ff && !limit_hit;
   assign mid_load  = list_hit && pend_valid_ff;
   assign better    = matrix_mode && hit && (!found_ff || rd_data < best_ff);
   assign last_issue = matrix_mode ? (scol_ff == lim_m1 && srow_ff == lim_m1)
                                   : (scol_ff == n_m1);

   // memory ports
   assign pa      = cmd.use_best ? ba_ff : in_row_v;
   assign pb      = cmd.use_best ? bb_ff : in_col_v;
   assign wr_en   = cmd.clear_step || cmd.write_fwd || cmd.write_rev;
   assign wr_addr = cmd.clear_step ? clr_addr_ff :
                    (cmd.write_rev ? cell_addr(pb, pa) : cell_addr(pa, pb));
   assign wr_data = (cmd.clear_step || cmd.write_zero) ? '0 : in_weight_ff;
   assign rd_en   = cmd.read_pair || issue;
   assign rd_addr = cmd.read_pair ? cell_addr(in_row_v, in_col_v)
                                  : cell_addr(srow_ff, scol_ff);

   wams_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff         <= wams_pkg::VERTEX_COUNT_RESET;
         clr_addr_ff   <= '0;
         issue_more_ff <= 1'b0;
         dvalid_ff     <= 1'b0;
         counter_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            vc_ff <= csr_write_data;
         end
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.scan_start) begin
            issue_more_ff <= !(matrix_mode && n_m1 == '0);
            dvalid_ff     <= 1'b0;
         end else if (advance) begin
            dvalid_ff <= issue;
            if (limit_hit || (issue && last_issue)) begin
               issue_more_ff <= 1'b0;
            end
         end
         if (cmd.bump_up && counter_ff != wams_pkg::COUNTER_MAX) begin
            counter_ff <= counter_ff + 16'sd1;
         end else if (cmd.bump_down && counter_ff != wams_pkg::COUNTER_MIN) begin
            counter_ff <= counter_ff - 16'sd1;
         end
         if (cmd.out_load || mid_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         in_cmd_ff    <= req_cmd;
         in_row_ff    <= req_row_vertex;
         in_col_ff    <= req_col_vertex;
         in_weight_ff <= WEIGHT_BITS'(req_edge_weight);
      end
      if (cmd.scan_start) begin
         srow_ff       <= matrix_mode ? '0 : in_row_v;
         scol_ff       <= '0;
         cnt_ff        <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else if (advance) begin
         drow_ff <= srow_ff;
         dcol_ff <= scol_ff;
         if (issue) begin
            if (matrix_mode && scol_ff == lim_m1) begin
               scol_ff <= '0;
               srow_ff <= srow_ff + 1'b1;
            end else begin
               scol_ff <= scol_ff + 1'b1;
            end
         end
         if (consume && hit) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (list_hit) begin
            pend_ff       <= dcol_ff;
            pend_valid_ff <= 1'b1;
            k_ff          <= k_next;
         end
         if (better) begin
            found_ff <= 1'b1;
            best_ff  <= rd_data;
            ba_ff    <= drow_ff;
            bb_ff    <= dcol_ff;
         end
      end
   end

   always_comb begin
      o_status  = wams_pkg::STATUS_OK;
      o_present = 1'b0;
      o_va      = '0;
      o_vb      = '0;
      o_weight  = '0;
      o_count   = '0;
      o_last    = 1'b1;
      if (mid_load) begin
         o_va   = VB'(pend_ff);
         o_last = 1'b0;
      end else begin
         unique case (cmd.out_kind)
            wams_pkg::OUT_RANGE: o_status = wams_pkg::STATUS_RANGE;
            wams_pkg::OUT_NONE:  o_status = wams_pkg::STATUS_NONE;
            wams_pkg::OUT_OK:    o_status = wams_pkg::STATUS_OK;
            wams_pkg::OUT_TEST:  o_present = (rd_data != '0);
            wams_pkg::OUT_DEGREE: o_count = cnt_ff;
            wams_pkg::OUT_LIST_END: begin
               if (pend_valid_ff) begin
                  o_va = VB'(pend_ff);
               end else begin
                  o_status = wams_pkg::STATUS_NONE;
               end
            end
            wams_pkg::OUT_LIGHTEST: begin
               o_va     = VB'(ba_ff);
               o_vb     = VB'(bb_ff);
               o_weight = FB'(best_ff);
            end
            default: o_status = wams_pkg::STATUS_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load || mid_load) begin
         rsp_status_ff  <= o_status;
         rsp_present_ff <= o_present;
         rsp_va_ff      <= o_va;
         rsp_vb_ff      <= o_vb;
         rsp_weight_ff  <= o_weight;
         rsp_count_ff   <= o_count;
         rsp_total_ff   <= counter_ff;
         rsp_last_ff    <= o_last;
      end
   end

   assign sts.clear_done = (clr_addr_ff == AW'(DEPTH - 1));
   assign sts.pair_ok    = row_ok && col_ok;
   assign sts.row_ok     = row_ok;
   assign sts.scan_done  = !dvalid_ff && !issue_more_ff;
   assign sts.best_found = found_ff;
   assign sts.out_free   = out_free;
   assign sts.cmd        = in_cmd_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_edge_present    = rsp_present_ff;
   assign rsp_vertex_a        = rsp_va_ff;
   assign rsp_vertex_b        = rsp_vb_ff;
   assign rsp_found_weight    = rsp_weight_ff;
   assign rsp_neighbour_count = rsp_count_ff;
   assign rsp_edges_total     = rsp_total_ff;
   assign rsp_last            = rsp_last_ff;

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, (cmd.out_load || mid_load) && rsp_valid_ff, !rsp_stall)
   `ASSERT_NEXT(a_counter_holds, clock, reset, !cmd.bump_up && !cmd.bump_down, $stable(counter_ff))
   `ASSERT_IMPLIES(a_scan_no_write, clock, reset, dvalid_ff, !wr_en)

endmodule

// File: verif/tb_weighted_adjacency_matrix_store.sv
`timescale 1ns / 100ps

module tb_weighted_adjacency_matrix_store;

   localparam int NUM_VERTICES     = 64;
   localparam int CYCLE_LIMIT      = 4000000;
   localparam int MAX_REPORTS      = 10;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 200;
   localparam int SETTLE_CYCLES    = 4;
   localparam int PHASE_ITEMS      = 2;
   localparam wams_pkg::cmd_type CMD_SPARE_6 = 3'd6;
   localparam wams_pkg::cmd_type CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      wams_pkg::cmd_type cmd;
      logic [5:0]        row;
      logic [5:0]        col;
      logic [15:0]       weight;
   } edge_cmd_type;

   typedef struct packed {
      wams_pkg::status_type status;
      logic                 present;
      logic [5:0]           vertex_a;
      logic [5:0]           vertex_b;
      logic [15:0]          weight;
      logic [6:0]           degree;
      logic signed [15:0]   total;
      logic                 last;
   } store_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_cmd = '0;
   logic [5:0]         req_row_vertex = '0;
   logic [5:0]         req_col_vertex = '0;
   logic [15:0]        req_edge_weight = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic               rsp_edge_present;
   logic [5:0]         rsp_vertex_a;
   logic [5:0]         rsp_vertex_b;
   logic [15:0]        rsp_found_weight;
   logic [6:0]         rsp_neighbour_count;
   logic signed [15:0] rsp_edges_total;
   logic               rsp_last;
   logic               csr_write_enable = 1'b0;
   logic [6:0]         csr_write_data = '0;

   // shadow copy of the store
   logic [15:0]        shadow_weights [0:NUM_VERTICES-1][0:NUM_VERTICES-1];
   logic signed [15:0] shadow_total = '0;
   logic [6:0]         shadow_vertex_count = wams_pkg::VERTEX_COUNT_RESET;

   edge_cmd_type       cmd_queue [$];
   store_reply_type    reply_queue [$];
   edge_cmd_type       drive_cmd;
   edge_cmd_type       seen_cmd;
   store_reply_type    seen_reply;

   int                 req_gap_left = 0;
   logic               req_beat_taken = 1'b0;
   int                 stall_left = 0;
   int                 stall_pick;
   int                 long_hold_left = 0;
   logic               long_hold_armed = 1'b0;
   logic               long_hold_done = 1'b0;
   logic               steady_flow = 1'b0;
   int                 error_count = 0;
   int                 cycle_count = 0;

   weighted_adjacency_matrix_store i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_row_vertex      (req_row_vertex),
      .req_col_vertex      (req_col_vertex),
      .req_edge_weight     (req_edge_weight),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_edge_present    (rsp_edge_present),
      .rsp_vertex_a        (rsp_vertex_a),
      .rsp_vertex_b        (rsp_vertex_b),
      .rsp_found_weight    (rsp_found_weight),
      .rsp_neighbour_count (rsp_neighbour_count),
      .rsp_edges_total     (rsp_edges_total),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int active_vertices();
      if (shadow_vertex_count == 0) return 1;
      if (shadow_vertex_count > NUM_VERTICES) return NUM_VERTICES;
      return int'(shadow_vertex_count);
   endfunction

   function automatic void bump_total(int delta);
      int sum;
      sum = int'(shadow_total) + delta;
      if (sum > int'(wams_pkg::COUNTER_MAX)) sum = int'(wams_pkg::COUNTER_MAX);
      if (sum < int'(wams_pkg::COUNTER_MIN)) sum = int'(wams_pkg::COUNTER_MIN);
      shadow_total = 16'(sum);
   endfunction

   function automatic void push_reply(wams_pkg::status_type status, logic present,
                                      logic [5:0] va, logic [5:0] vb, logic [15:0] w,
                                      logic [6:0] degree, logic last);
      store_reply_type r;
      r.status   = status;
      r.present  = present;
      r.vertex_a = va;
      r.vertex_b = vb;
      r.weight   = w;
      r.degree   = degree;
      r.total    = shadow_total;
      r.last     = last;
      reply_queue.push_back(r);
   endfunction

   function automatic void set_pair(logic [5:0] a, logic [5:0] b, logic [15:0] w);
      shadow_weights[a][b] = w;
      shadow_weights[b][a] = w;
   endfunction

   function automatic void predict_replies(edge_cmd_type item);
      int          n;
      int          lim;
      int          hits;
      logic        found;
      logic [15:0] best;
      logic [5:0]  best_a;
      logic [5:0]  best_b;
      logic [6:0]  degree;
      n = active_vertices();
      case (item.cmd) inside
         wams_pkg::CMD_ADD, wams_pkg::CMD_REMOVE, wams_pkg::CMD_TEST: begin
            if (item.row >= n || item.col >= n) begin
               push_reply(wams_pkg::STATUS_RANGE, 1'b0, '0, '0, '0, '0, 1'b1);
            end else if (item.cmd == wams_pkg::CMD_ADD) begin
               set_pair(item.row, item.col, item.weight);
               bump_total(1);
               push_reply(wams_pkg::STATUS_OK, 1'b0, '0, '0, '0, '0, 1'b1);
            end else if (item.cmd == wams_pkg::CMD_REMOVE) begin
               set_pair(item.row, item.col, '0);
               bump_total(-1);
               push_reply(wams_pkg::STATUS_OK, 1'b0, '0, '0, '0, '0, 1'b1);
            end else begin
               push_reply(wams_pkg::STATUS_OK, shadow_weights[item.row][item.col] != 0,
                          '0, '0, '0, '0, 1'b1);
            end
         end
         wams_pkg::CMD_DEGREE: begin
            if (item.row >= n) begin
               push_reply(wams_pkg::STATUS_RANGE, 1'b0, '0, '0, '0, '0, 1'b1);
            end else begin
               degree = '0;
               for (int i = 0; i < n; i++)
                  if (shadow_weights[item.row][i] != 0) degree = degree + 1'b1;
               push_reply(wams_pkg::STATUS_OK, 1'b0, '0, '0, '0, degree, 1'b1);
            end
         end
         wams_pkg::CMD_LIST: begin
            if (item.row >= n) begin
               push_reply(wams_pkg::STATUS_RANGE, 1'b0, '0, '0, '0, '0, 1'b1);
            end else begin
               hits = 0;
               for (int i = 0; i < n && hits < int'(wams_pkg::LIST_LIMIT); i++) begin
                  if (shadow_weights[item.row][i] != 0) begin
                     push_reply(wams_pkg::STATUS_OK, 1'b0, 6'(i), '0, '0, '0, 1'b0);
                     hits++;
                  end
               end
               if (hits == 0)
                  push_reply(wams_pkg::STATUS_NONE, 1'b0, '0, '0, '0, '0, 1'b1);
               else
                  reply_queue[reply_queue.size()-1].last = 1'b1;
            end
         end
         wams_pkg::CMD_LIGHTEST: begin
            // the scan leaves out the top vertex, row and column alike
            lim    = n - 1;
            found  = 1'b0;
            best   = '0;
            best_a = '0;
            best_b = '0;
            for (int i = 0; i < lim; i++) begin
               for (int j = 0; j < lim; j++) begin
                  if (shadow_weights[i][j] != 0 && (!found || shadow_weights[i][j] < best)) begin
                     found  = 1'b1;
                     best   = shadow_weights[i][j];
                     best_a = 6'(i);
                     best_b = 6'(j);
                  end
               end
            end
            if (!found) begin
               push_reply(wams_pkg::STATUS_NONE, 1'b0, '0, '0, '0, '0, 1'b1);
            end else begin
               set_pair(best_a, best_b, '0);
               bump_total(-1);
               push_reply(wams_pkg::STATUS_OK, 1'b0, best_a, best_b, best, '0, 1'b1);
            end
         end
         default: begin
            push_reply(wams_pkg::STATUS_NONE, 1'b0, '0, '0, '0, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic string reply_text(store_reply_type r);
      return {$sformatf("status=%0d present=%0d a=%0d b=%0d ",
                        r.status, r.present, r.vertex_a, r.vertex_b),
              $sformatf("weight=%0d degree=%0d total=%0d last=%0d",
                        r.weight, r.degree, r.total, r.last)};
   endfunction

   function automatic void check_reply(store_reply_type got);
      store_reply_type want;
      if (reply_queue.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("unexpected result beat: %s", reply_text(got));
      end else begin
         want = reply_queue.pop_front();
         if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("result mismatch at cycle %0d", cycle_count);
               $display("   expected %s", reply_text(want));
               $display("   actual   %s", reply_text(got));
            end
         end
      end
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [5:0] pick_vertex(int n);
      if ($urandom_range(0, 99) < 88) return 6'($urandom_range(0, n - 1));
      return 6'($urandom_range(0, NUM_VERTICES - 1));
   endfunction

   function automatic logic [15:0] pick_weight();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return 16'hFFFF;
      if (roll < 50) return 16'($urandom_range(1, 8));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic edge_cmd_type random_cmd();
      edge_cmd_type c;
      int           n;
      int           roll;
      n    = active_vertices();
      roll = $urandom_range(0, 99);
      if (roll < 35)      c.cmd = wams_pkg::CMD_ADD;
      else if (roll < 45) c.cmd = wams_pkg::CMD_REMOVE;
      else if (roll < 60) c.cmd = wams_pkg::CMD_TEST;
      else if (roll < 70) c.cmd = wams_pkg::CMD_DEGREE;
      else if (roll < 84) c.cmd = wams_pkg::CMD_LIST;
      else if (roll < 94) c.cmd = wams_pkg::CMD_LIGHTEST;
      else                c.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      c.row    = pick_vertex(n);
      c.col    = pick_vertex(n);
      c.weight = pick_weight();
      return c;
   endfunction

   function automatic void queue_cmd(wams_pkg::cmd_type cmd, int row, int col, int weight);
      edge_cmd_type c;
      c.cmd    = cmd;
      c.row    = 6'(row);
      c.col    = 6'(col);
      c.weight = 16'(weight);
      cmd_queue.push_back(c);
   endfunction

   task automatic wait_until_drained();
      do @(posedge clock);
      while (cmd_queue.size() != 0 || req_valid || reply_queue.size() != 0);
   endtask

   task automatic write_vertex_count(logic [6:0] value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      shadow_vertex_count = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // request driver: hold a stalled beat, otherwise gap or send the next one
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_beat_taken)) begin
         if (req_gap_left > 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (cmd_queue.size() > 0) begin
            drive_cmd = cmd_queue.pop_front();
            req_cmd         <= drive_cmd.cmd;
            req_row_vertex  <= drive_cmd.row;
            req_col_vertex  <= drive_cmd.col;
            req_edge_weight <= drive_cmd.weight;
            req_valid       <= 1'b1;
            req_gap_left    <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, one long hold-off once armed, no stalls in steady flow
   always @(negedge clock) begin
      if (long_hold_left > 0) begin
         rsp_stall      <= 1'b1;
         long_hold_left <= long_hold_left - 1;
      end else if (long_hold_armed && !long_hold_done) begin
         rsp_stall      <= 1'b1;
         long_hold_left <= LONG_HOLD_CYCLES - 1;
         long_hold_done <= 1'b1;
      end else if (steady_flow) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_pick = pick_gap();
         rsp_stall  <= (stall_pick > 0);
         stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
      end
   end

   // monitor: predict on each request beat, check each result beat
   always @(posedge clock) begin
      req_beat_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen_cmd.cmd    = req_cmd;
            seen_cmd.row    = req_row_vertex;
            seen_cmd.col    = req_col_vertex;
            seen_cmd.weight = req_edge_weight;
            predict_replies(seen_cmd);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_reply.status   = rsp_status;
            seen_reply.present  = rsp_edge_present;
            seen_reply.vertex_a = rsp_vertex_a;
            seen_reply.vertex_b = rsp_vertex_b;
            seen_reply.weight   = rsp_found_weight;
            seen_reply.degree   = rsp_neighbour_count;
            seen_reply.total    = rsp_edges_total;
            seen_reply.last     = rsp_last;
            check_reply(seen_reply);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_weighted_adjacency_matrix_store: FAIL");
         $finish;
      end
   end

   initial begin
      logic [6:0] phase_counts [0:7];
      for (int i = 0; i < NUM_VERTICES; i++)
         for (int j = 0; j < NUM_VERTICES; j++)
            shadow_weights[i][j] = '0;
      phase_counts = '{7'd127, 7'd0, 7'd1, 7'd2, 7'd9, 7'd33, 7'd64, 7'd0};
      phase_counts[7] = 7'($urandom_range(3, 20));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // wait out the clearing pass
      do @(posedge clock);
      while (req_stall);

      // directed: small graph, edges of vertex 5 are outside the lightest scan
      write_vertex_count(7'd6);
      queue_cmd(wams_pkg::CMD_LIGHTEST, 0, 0, 0);
      queue_cmd(wams_pkg::CMD_LIST, 0, 0, 0);
      queue_cmd(wams_pkg::CMD_DEGREE, 0, 0, 0);
      queue_cmd(wams_pkg::CMD_TEST, 0, 1, 0);
      queue_cmd(wams_pkg::CMD_ADD, 0, 1, 16'hFFFF);
      queue_cmd(wams_pkg::CMD_ADD, 1, 2, 1);
      queue_cmd(wams_pkg::CMD_ADD, 2, 2, 7);
      queue_cmd(wams_pkg::CMD_ADD, 3, 0, 0);
      queue_cmd(wams_pkg::CMD_ADD, 0, 5, 16'h8000);
      queue_cmd(wams_pkg::CMD_TEST, 1, 0, 0);
      queue_cmd(wams_pkg::CMD_TEST, 0, 3, 0);
      queue_cmd(wams_pkg::CMD_DEGREE, 0, 0, 0);
      queue_cmd(wams_pkg::CMD_LIST, 0, 0, 0);
      queue_cmd(wams_pkg::CMD_LIST, 2, 0, 0);
      queue_cmd(wams_pkg::CMD_ADD, 6, 0, 16'h5555);
      queue_cmd(wams_pkg::CMD_TEST, 0, 63, 0);
      queue_cmd(wams_pkg::CMD_DEGREE, 63, 63, 0);
      queue_cmd(wams_pkg::CMD_LIST, 6, 0, 0);
      queue_cmd(wams_pkg::CMD_REMOVE, 3, 0, 0);
      queue_cmd(CMD_SPARE_6, 63, 63, 16'hFFFF);
      queue_cmd(CMD_SPARE_7, 0, 0, 0);
      queue_cmd(wams_pkg::CMD_LIGHTEST, 0, 0, 0);
      queue_cmd(wams_pkg::CMD_LIGHTEST, 0, 0, 0);
      queue_cmd(wams_pkg::CMD_REMOVE, 0, 1, 0);
      queue_cmd(wams_pkg::CMD_LIGHTEST, 0, 0, 0);
      wait_until_drained();

      // full row under a long receiver hold-off, then the longest list
      write_vertex_count(7'd64);
      long_hold_armed = 1'b1;
      for (int v = 0; v < NUM_VERTICES; v++)
         queue_cmd(wams_pkg::CMD_ADD, 10, v, $urandom_range(1, 65535));
      queue_cmd(wams_pkg::CMD_LIST, 10, 0, 0);
      queue_cmd(wams_pkg::CMD_DEGREE, 10, 0, 0);
      queue_cmd(wams_pkg::CMD_LIGHTEST, 0, 0, 0);
      wait_until_drained();

      for (int p = 0; p < 8; p++) begin
         write_vertex_count(phase_counts[p]);
         steady_flow = (p % 3 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++)
            cmd_queue.push_back(random_cmd());
         wait_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count = error_count + reply_queue.size();
      if (error_count == 0) begin
         $display("tb_weighted_adjacency_matrix_store: PASS");
      end else begin
         $display("tb_weighted_adjacency_matrix_store: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/wams_pkg.sv
src/wams_ram.sv
src/wams_ctrl.sv
src/wams_datapath.sv
src/weighted_adjacency_matrix_store.sv
verif/tb_weighted_adjacency_matrix_store.sv
